// ----- rtl/ofjpm_pkg.sv -----
package ofjpm_pkg;

  localparam logic [7:0] SHUTTER_LIMIT = 8'd17;
  localparam logic [7:0] BRIGHT_LIMIT = 8'd50;
  localparam logic [3:0] JAM_ERROR_LIMIT = 4'd10;
  localparam logic [3:0] JAM_ERROR_MAX = 4'd15;
  localparam logic [7:0] FILTER_MAX = 8'd255;

  localparam logic [14:0] CHUNK_STEPS_RESET = 15'd128;
  localparam logic [7:0] FILTER_COUNT_RESET = 8'd4;

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_JAM_ENABLE = 2'd0,
    CFG_CHUNK_STEPS = 2'd1,
    CFG_FILTER_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [6:0] step_delta;
    logic signed [15:0] sensor_y;
    logic [7:0] shutter;
    logic [7:0] brightness;
    logic poll_due;
  } sample_t;

  typedef struct packed {
    logic filament_present;
    logic presence_stable;
    logic jam_detected;
    logic jam_armed_now;
  } result_t;

endpackage

// ----- rtl/optical_filament_jam_presence_monitor.sv -----
// Filament jam and presence monitor for an optical flow sensor. Each sample word carries the
// extruder steps of one tick, the sensor Y position, shutter, brightness and a poll flag, and
// gives exactly one result word. A word is registered on entry and its result is computed by
// one pass of logic into the output register, so a new word is taken every cycle while the
// output side does not stall. Configuration writes are always accepted (cfg_ready is
// always high) and are meant for an idle block. Writing jam_enable arms or disarms jam
// detection and restarts it from the latest sensor position.
module optical_filament_jam_presence_monitor
  import ofjpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic sample_valid,
  output logic sample_stall,
  input  sample_t sample,
  output logic result_valid,
  input  logic result_stall,
  output result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic s1_valid;
  sample_t s1;
  logic advance;

  logic [14:0] chunk_steps;
  logic [7:0] filter_count;

  logic signed [15:0] step_sum;
  logic signed [15:0] ref_position;
  logic signed [15:0] last_sensor_y;
  logic [3:0] jam_errors;
  logic jam_armed;
  logic [7:0] presence_filter;
  logic filtered_presence;

  logic signed [15:0] step_sum_next;
  logic signed [15:0] ref_position_next;
  logic [3:0] jam_errors_next;
  logic jam_armed_next;
  logic [7:0] presence_filter_next;
  logic filtered_presence_next;
  logic jam_pulse;

  logic signed [16:0] sum_wide;
  logic signed [15:0] sum_sat;
  logic signed [16:0] sum_neg;
  logic [16:0] sum_mag;
  logic signed [16:0] y_diff;
  logic fs_fwd;
  logic st_fwd;
  logic [3:0] err_step;
  logic present;
  logic [7:0] filt_step;

  assign advance = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    sum_wide = {step_sum[15], step_sum} + {{10{s1.step_delta[6]}}, s1.step_delta};
    if (sum_wide[16] != sum_wide[15]) begin
      sum_sat = sum_wide[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sum_sat = sum_wide[15:0];
    end
    sum_neg = -{sum_sat[15], sum_sat};
    sum_mag = sum_sat[15] ? 17'(sum_neg) : {1'b0, sum_sat};
    y_diff = {s1.sensor_y[15], s1.sensor_y} - {ref_position[15], ref_position};
    fs_fwd = y_diff > 17'sd0;
    st_fwd = sum_sat > 16'sd0;

    step_sum_next = sum_sat;
    ref_position_next = ref_position;
    jam_errors_next = jam_errors;
    jam_armed_next = jam_armed;
    jam_pulse = 1'b0;
    err_step = jam_errors;

    if (jam_armed) begin
      if (sum_mag >= {2'b00, chunk_steps}) begin
        step_sum_next = 16'sd0;
        ref_position_next = s1.sensor_y;
        if (fs_fwd != st_fwd) begin
          if (jam_errors < JAM_ERROR_MAX) begin
            err_step = jam_errors + 4'd1;
          end
        end else if (jam_errors != 4'd0) begin
          err_step = jam_errors - 4'd1;
        end
      end
      jam_errors_next = err_step;
      if (err_step > JAM_ERROR_LIMIT) begin
        jam_errors_next = 4'd0;
        jam_pulse = 1'b1;
        jam_armed_next = 1'b0;
      end
    end

    present = (s1.shutter < SHUTTER_LIMIT) || (s1.brightness >= BRIGHT_LIMIT);
    presence_filter_next = presence_filter;
    filtered_presence_next = filtered_presence;
    filt_step = presence_filter;
    if (s1.poll_due) begin
      if (present != filtered_presence) begin
        if (presence_filter < FILTER_MAX) begin
          filt_step = presence_filter + 8'd1;
        end
      end else if (presence_filter != 8'd0) begin
        filt_step = presence_filter - 8'd1;
      end
      presence_filter_next = filt_step;
      if (filt_step >= filter_count) begin
        presence_filter_next = 8'd0;
        filtered_presence_next = present;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1 <= sample;
    end
    if (advance) begin
      result.filament_present <= filtered_presence_next;
      result.presence_stable <= presence_filter_next == 8'd0;
      result.jam_detected <= jam_pulse;
      result.jam_armed_now <= jam_armed_next;
    end
    if (rst) begin
      s1_valid <= 1'b0;
      result_valid <= 1'b0;
      chunk_steps <= CHUNK_STEPS_RESET;
      filter_count <= FILTER_COUNT_RESET;
      step_sum <= 16'sd0;
      ref_position <= 16'sd0;
      last_sensor_y <= 16'sd0;
      jam_errors <= 4'd0;
      jam_armed <= 1'b0;
      presence_filter <= 8'd0;
      filtered_presence <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (advance) begin
        step_sum <= step_sum_next;
        ref_position <= ref_position_next;
        last_sensor_y <= s1.sensor_y;
        jam_errors <= jam_errors_next;
        jam_armed <= jam_armed_next;
        presence_filter <= presence_filter_next;
        filtered_presence <= filtered_presence_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_JAM_ENABLE: begin
            jam_armed <= cfg_data[0];
            ref_position <= last_sensor_y;
            step_sum <= 16'sd0;
            jam_errors <= 4'd0;
          end
          CFG_CHUNK_STEPS: begin
            chunk_steps <= cfg_data[14:0];
          end
          CFG_FILTER_COUNT: begin
            filter_count <= cfg_data[7:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The stored error count never passes the limit, since passing it clears the count.
  assert property (@(posedge clk) disable iff (rst) jam_errors <= JAM_ERROR_LIMIT)
    else $error("jam error count above limit");

  // A jam word always reports detection as disarmed.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.jam_detected |-> !result.jam_armed_now)
    else $error("jam pulse while still armed");

  // The stable flag of a new result word matches the filter state it leaves behind.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> result.presence_stable == (presence_filter == 8'd0))
    else $error("presence_stable disagrees with filter");

  // The input side is held off only while a word waits behind a stalled output.
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without cause");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import ofjpm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  sample_t sample;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  optical_filament_jam_presence_monitor i_dut (.*);

  // Predicted monitor state and register copies.
  int sum_steps = 0;
  int ref_y = 0;
  int last_y = 0;
  logic [3:0] error_count = '0;
  logic armed = 1'b0;
  logic [7:0] filter_level = '0;
  logic presence = 1'b0;
  logic [14:0] chunk_len = CHUNK_STEPS_RESET;
  logic [7:0] filter_commit = FILTER_COUNT_RESET;

  result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_len = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t predict_result(input sample_t s);
    int y;
    int mag;
    logic sensor_fwd;
    logic steps_fwd;
    logic present;
    result_t r;
    y = int'(s.sensor_y);
    r.jam_detected = 1'b0;
    sum_steps = sum_steps + int'(s.step_delta);
    if (sum_steps > 32767) sum_steps = 32767;
    if (sum_steps < -32768) sum_steps = -32768;
    if (armed) begin
      mag = (sum_steps < 0) ? -sum_steps : sum_steps;
      if (mag >= int'(chunk_len)) begin
        sensor_fwd = (y - ref_y) > 0;
        steps_fwd = sum_steps > 0;
        sum_steps = 0;
        if (sensor_fwd != steps_fwd) begin
          if (error_count < JAM_ERROR_MAX) error_count++;
        end else if (error_count != 4'd0) begin
          error_count--;
        end
        ref_y = y;
      end
      if (error_count > JAM_ERROR_LIMIT) begin
        error_count = '0;
        r.jam_detected = 1'b1;
        armed = 1'b0;
      end
    end
    if (s.poll_due) begin
      present = (s.shutter < SHUTTER_LIMIT) || (s.brightness >= BRIGHT_LIMIT);
      if (present != presence) begin
        if (filter_level < FILTER_MAX) filter_level++;
      end else if (filter_level != 8'd0) begin
        filter_level--;
      end
      if (filter_level >= filter_commit) begin
        filter_level = '0;
        presence = present;
      end
    end
    last_y = y;
    r.filament_present = presence;
    r.presence_stable = (filter_level == 8'd0);
    r.jam_armed_now = armed;
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    case (idx)
      CFG_JAM_ENABLE: begin
        armed = value[0];
        ref_y = last_y;
        sum_steps = 0;
        error_count = '0;
      end
      CFG_CHUNK_STEPS: chunk_len = value[14:0];
      CFG_FILTER_COUNT: filter_commit = value[7:0];
      default: ;
    endcase
  endfunction

  function automatic sample_t make_sample(input int delta, input int y, input int shut,
                                          input int bright, input int poll);
    sample_t s;
    s.step_delta = 7'(delta);
    s.sensor_y = 16'(y);
    s.shutter = 8'(shut);
    s.brightness = 8'(bright);
    s.poll_due = 1'(poll);
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("result word %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_results.push_back(predict_result(s));
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    apply_cfg(idx, value);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side stall, with an occasional long hold-off.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        result_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("no word was expected");
      end else begin
        want = expected_results.pop_front();
        if (result.filament_present !== want.filament_present)
          report_mismatch($sformatf("filament_present %b, expected %b",
                                    result.filament_present, want.filament_present));
        if (result.presence_stable !== want.presence_stable)
          report_mismatch($sformatf("presence_stable %b, expected %b",
                                    result.presence_stable, want.presence_stable));
        if (result.jam_detected !== want.jam_detected)
          report_mismatch($sformatf("jam_detected %b, expected %b",
                                    result.jam_detected, want.jam_detected));
        if (result.jam_armed_now !== want.jam_armed_now)
          report_mismatch($sformatf("jam_armed_now %b, expected %b",
                                    result.jam_armed_now, want.jam_armed_now));
      end
      results_seen++;
    end
  end

  task automatic test_field_extremes();
    send_sample(make_sample(-64, -32768, 0, 0, 1));
    send_sample(make_sample(63, 32767, 16, 0, 1));
    send_sample(make_sample(0, 0, 17, 49, 1));
    send_sample(make_sample(-1, 1, 255, 50, 1));
    send_sample(make_sample(1, -1, 255, 255, 1));
    send_sample(make_sample(0, 0, 17, 255, 1));
    send_sample(make_sample(0, 0, 255, 0, 0));
    send_sample(make_sample(0, 0, 0, 0, 0));
  endtask

  // Three misses, an agreeing chunk, a zero sensor move taken as backward, then
  // enough misses to pass ten and fire the jam pulse.
  task automatic test_jam_pulse();
    int y;
    settle();
    write_cfg(CFG_CHUNK_STEPS, 1);
    write_cfg(CFG_JAM_ENABLE, 1);
    y = last_y;
    repeat (3) begin
      y -= 5;
      send_sample(make_sample(1, y, 255, 0, 0));
    end
    y += 5;
    send_sample(make_sample(1, y, 255, 0, 0));
    send_sample(make_sample(-1, y, 255, 0, 0));
    repeat (10) begin
      y -= 5;
      send_sample(make_sample(1, y, 255, 0, 0));
    end
    send_sample(make_sample(1, y - 5, 255, 0, 0));
  endtask

  task automatic test_zero_settings();
    settle();
    write_cfg(CFG_CHUNK_STEPS, 0);
    write_cfg(CFG_FILTER_COUNT, 0);
    write_cfg(CFG_JAM_ENABLE, 1);
    send_sample(make_sample(0, last_y + 10, 255, 0, 1));
    send_sample(make_sample(0, last_y - 3, 0, 0, 1));
    send_sample(make_sample(5, last_y + 7, 255, 0, 0));
    send_sample(make_sample(-5, last_y, 255, 49, 1));
    settle();
    write_cfg(CFG_UNMAPPED, 32'hffff_ffff);
    send_sample(make_sample(3, last_y + 2, 10, 0, 1));
    send_sample(make_sample(-3, last_y + 2, 255, 0, 1));
  endtask

  // The widest chunk: the step sum climbs to its limit before one check closes.
  task automatic test_max_chunk();
    int y;
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_FILTER_COUNT, 4);
    write_cfg(CFG_CHUNK_STEPS, 32767);
    write_cfg(CFG_JAM_ENABLE, 1);
    y = 0;
    repeat (522) begin
      y += 1;
      send_sample(make_sample(63, y, 255, 0, 0));
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_cfg(CFG_CHUNK_STEPS, 20);
    write_cfg(CFG_JAM_ENABLE, 1);
    send_idle_pct = 0;
    recv_idle_pct = 30;
    hold_len = 300;
    repeat (40)
      send_sample(make_sample($urandom_range(0, 20), $urandom_range(0, 2000),
                              $urandom_range(255), $urandom_range(255), $urandom_range(1)));
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int dir;
    int pos;
    int agree_pct;
    bit want_present;
    sample_t s;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    dir = 1;
    want_present = 1'b0;
    while (sent < n_items) begin
      settle();
      pos = last_y;
      case ($urandom_range(7))
        0: write_cfg(CFG_CHUNK_STEPS, 0);
        1: write_cfg(CFG_CHUNK_STEPS, 1);
        2: write_cfg(CFG_CHUNK_STEPS, $urandom_range(32767));
        default: write_cfg(CFG_CHUNK_STEPS, $urandom_range(2, 200));
      endcase
      case ($urandom_range(5))
        0: write_cfg(CFG_FILTER_COUNT, 0);
        1: write_cfg(CFG_FILTER_COUNT, 255);
        default: write_cfg(CFG_FILTER_COUNT, $urandom_range(1, 6));
      endcase
      write_cfg(CFG_JAM_ENABLE, 32'($urandom_range(5) != 0));
      case ($urandom_range(2))
        0: agree_pct = 10;
        1: agree_pct = 50;
        default: agree_pct = 90;
      endcase
      repeat ($urandom_range(40, 90)) begin
        if ($urandom_range(7) == 0) begin
          s = make_sample($urandom_range(127), $urandom_range(65535), $urandom_range(255),
                          $urandom_range(255), $urandom_range(1));
        end else begin
          if ($urandom_range(15) == 0) dir = -dir;
          if ($urandom_range(9) == 0) want_present = !want_present;
          if ($urandom_range(99) < agree_pct) pos += dir * $urandom_range(1, 40);
          else pos -= dir * $urandom_range(1, 40);
          s = make_sample(dir * $urandom_range(1, 63), pos, 0, 0, $urandom_range(1));
          if (want_present && $urandom_range(1)) begin
            s.shutter = 8'($urandom_range(0, 16));
            s.brightness = 8'($urandom_range(255));
          end else if (want_present) begin
            s.shutter = 8'($urandom_range(17, 255));
            s.brightness = 8'($urandom_range(50, 255));
          end else begin
            s.shutter = 8'($urandom_range(17, 255));
            s.brightness = 8'($urandom_range(0, 49));
          end
        end
        send_sample(s);
        sent++;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_JAM_ENABLE;
    cfg_data <= '0;
    send_idle_pct = 10;
    recv_idle_pct = 66;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_jam_pulse();
    test_zero_settings();
    test_max_chunk();
    test_backpressure();
    test_random_traffic(10, 66, 200);
    test_random_traffic(66, 10, 200);
    test_random_traffic(0, 0, 200);
    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ofjpm_pkg.sv
rtl/optical_filament_jam_presence_monitor.sv
tb/testbench.sv
